// ===== design/dsi_pkg.sv =====
// Package for the deduplication similarity index.
// Holds payload structs, config layout, command/status types and hash constants.
// No dependencies.
package dsi_pkg;

    typedef struct packed {
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [1:0]  table_index;
        logic [63:0] byte_offset;
        logic [31:0] byte_count;
        logic        mode;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] match_offset;
        logic [31:0] match_size;
        logic        inserted;
        logic        recycled;
    } result_t;

    typedef struct packed {
        logic [2:0]  key_words;
        logic        simple_mode;
        logic [10:0] slots_in_use;
        logic [15:0] entry_limit;
    } cfg_t;

    // register indexes on the config port
    localparam logic [1:0] REG_KEY_WORDS   = 2'd0;
    localparam logic [1:0] REG_SIMPLE_MODE = 2'd1;
    localparam logic [1:0] REG_SLOTS       = 2'd2;
    localparam logic [1:0] REG_ENTRY_LIMIT = 2'd3;

    localparam logic [2:0]  RST_KEY_WORDS   = 3'd4;
    localparam logic        RST_SIMPLE_MODE = 1'b1;
    localparam logic [10:0] RST_SLOTS       = 11'd1024;
    localparam logic [15:0] RST_ENTRY_LIMIT = 16'd32768;

    localparam logic [31:0] PR1 = 32'd2654435761;
    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;
    // floor(x/3) = (x * DIV3_RECIP) >> 33 for any 32-bit x
    localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_LANE_A,
        OP_LANE_B,
        OP_CONV,
        OP_TAIL_A,
        OP_TAIL_B,
        OP_FIN_A,
        OP_FIN_B,
        OP_FIN_C,
        OP_DIVQ,
        OP_MOD_STEP,
        OP_BKT_RD,
        OP_WAY_CLR,
        OP_ENT_RD,
        OP_ENT_CMP,
        OP_INSERT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;   // word index in hash phases
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [2:0] kw_eff;
        logic       mode;
        logic       hit;
        logic       bkt_empty;
        logic       way_last;
    } sts_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LANE_A,
        ST_LANE_B,
        ST_CONV,
        ST_TAIL_A,
        ST_TAIL_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_DIVQ,
        ST_MOD,
        ST_BKT_RD,
        ST_BKT_CHK,
        ST_ENT_RD,
        ST_ENT_CMP,
        ST_INSERT,
        ST_DONE
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== design/dsi_ctrl.sv =====
// Controller for the deduplication similarity index.
// Sequences hash, remainder, bucket walk and insert; depends on dsi_pkg.
module dsi_ctrl
    import dsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] lane_last, tail_last;

    assign lane_last = (sts.kw_eff == 3'd4) ? 5'd7 : 5'd3;
    assign tail_last = (sts.kw_eff == 3'd1) ? 5'd1 : 5'd5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                step_next = '0;
                if (start)
                    state_next = (sts.kw_eff >= 3'd2) ? ST_LANE_A : ST_TAIL_A;
            end
            ST_LANE_A: state_next = ST_LANE_B;
            ST_LANE_B:
            begin
                if (step_reg == lane_last)
                    state_next = ST_CONV;
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_LANE_A;
                end
            end
            ST_CONV:
            begin
                if (sts.kw_eff == 3'd3)
                begin
                    step_next  = 5'd4;
                    state_next = ST_TAIL_A;
                end
                else
                    state_next = ST_FIN_A;
            end
            ST_TAIL_A: state_next = ST_TAIL_B;
            ST_TAIL_B:
            begin
                if (step_reg == tail_last)
                    state_next = ST_FIN_A;
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_TAIL_A;
                end
            end
            ST_FIN_A: state_next = ST_FIN_B;
            ST_FIN_B: state_next = ST_FIN_C;
            ST_FIN_C: state_next = ST_DIVQ;
            ST_DIVQ:
            begin
                step_next  = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                    state_next = ST_BKT_RD;
            end
            ST_BKT_RD: state_next = ST_BKT_CHK;
            ST_BKT_CHK:
            begin
                if (!sts.bkt_empty)
                    state_next = ST_ENT_RD;
                else
                    state_next = sts.mode ? ST_INSERT : ST_DONE;
            end
            ST_ENT_RD: state_next = ST_ENT_CMP;
            ST_ENT_CMP:
            begin
                if (sts.hit)
                    state_next = ST_DONE;
                else if (sts.way_last)
                    state_next = sts.mode ? ST_INSERT : ST_DONE;
                else
                    state_next = ST_ENT_RD;
            end
            ST_INSERT: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NOP;
        cmd.step = step_reg;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   cmd.op = OP_CLEAR;
            ST_IDLE:
            begin
                busy   = 1'b0;
                cmd.op = start ? OP_LOAD : OP_NOP;
            end
            ST_LANE_A:  cmd.op = OP_LANE_A;
            ST_LANE_B:  cmd.op = OP_LANE_B;
            ST_CONV:    cmd.op = OP_CONV;
            ST_TAIL_A:  cmd.op = OP_TAIL_A;
            ST_TAIL_B:  cmd.op = OP_TAIL_B;
            ST_FIN_A:   cmd.op = OP_FIN_A;
            ST_FIN_B:   cmd.op = OP_FIN_B;
            ST_FIN_C:   cmd.op = OP_FIN_C;
            ST_DIVQ:    cmd.op = OP_DIVQ;
            ST_MOD:     cmd.op = OP_MOD_STEP;
            ST_BKT_RD:  cmd.op = OP_BKT_RD;
            ST_BKT_CHK: cmd.op = OP_WAY_CLR;
            ST_ENT_RD:  cmd.op = OP_ENT_RD;
            ST_ENT_CMP: cmd.op = OP_ENT_CMP;
            ST_INSERT:  cmd.op = OP_INSERT;
            ST_DONE:    done   = 1'b1;
            default:    cmd.op = OP_NOP;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENT_CMP && sts.hit) |=> state_reg == ST_DONE)
        else $error("hit did not end the bucket walk");
`endif

endmodule

// ===== design/dsi_dp.sv =====
// Datapath for the deduplication similarity index: XXH32 with one shared
// multiplier, bit-serial remainder, bucket and entry memories. Uses dsi_pkg.
module dsi_dp
    import dsi_pkg::*;
#(
    parameter int TABLES        = 4,
    parameter int SLOTS         = 1024,
    parameter int WAYS          = 8,
    parameter int KEY_WORDS_MAX = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  cmd_t    cmd,
    input  item_t   item,
    output sts_t    sts,
    output result_t result
);

    localparam int NBKT = TABLES * SLOTS;
    localparam int BW   = $clog2(NBKT);
    localparam int HW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW   = $clog2(WAYS + 1);
    localparam int SUMW = CW + 1;
    localparam int TW   = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int SW   = $clog2(SLOTS + 1);
    localparam int NENT = NBKT * (2 ** HW);
    localparam int KEYW = KEY_WORDS_MAX * 64;
    localparam int EWID = KEYW + 96;
    localparam int BKW  = HW + CW;

    function automatic logic [TW-1:0] tbl_mod(input logic [1:0] t);
        logic [4:0] v;
        v = {3'b000, t};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 5'(TABLES))
                v = v - 5'(TABLES);
        end
        return TW'(v);
    endfunction

    function automatic logic [HW-1:0] way_add(input logic [HW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [SUMW-1:0] s;
        s = SUMW'(a) + SUMW'(b);
        if (s >= SUMW'(WAYS))
            s = s - SUMW'(WAYS);
        return HW'(s);
    endfunction

    item_t           item_reg;
    result_t         res_reg;
    logic [31:0]     h_reg, t_reg;
    logic [31:0]     v_reg [4];
    logic [SW:0]     rem_reg;
    logic [BKW-1:0]  bkt_rdata_reg;
    logic [EWID-1:0] ent_rdata_reg;
    logic [CW-1:0]   way_reg;
    logic [15:0]     used_reg;
    logic [BW-1:0]   clr_reg;

    logic [BKW-1:0]  bkt_mem [NBKT];
    logic [EWID-1:0] ent_mem [NENT];

    logic [2:0]      kw_eff;
    logic [5:0]      len;
    logic [SW-1:0]   slots_eff;
    logic [63:0]     key_w [4];
    logic [63:0]     word64;
    logic [31:0]     word32;
    logic [31:0]     mul_a, mul_b;
    logic [63:0]     prod;
    logic [31:0]     conv_sum, divq;
    logic [SW:0]     rem_sh, rem_next;
    logic [BW-1:0]   bkt_idx;
    logic [HW-1:0]   head, rd_way, ins_way, head_inc;
    logic [CW-1:0]   cnt;
    logic [KEYW-1:0] key_row, st_key;
    logic [63:0]     st_off;
    logic [31:0]     st_size;
    logic            key_eq, hit, recycle;
    logic [BKW-1:0]  bkt_new;

    // config clamps
    always_comb
    begin
        if (cfg.key_words == 3'd0)
            kw_eff = 3'd1;
        else if (cfg.key_words > 3'(KEY_WORDS_MAX))
            kw_eff = 3'(KEY_WORDS_MAX);
        else
            kw_eff = cfg.key_words;
        if (cfg.slots_in_use == 11'd0)
            slots_eff = SW'(1);
        else if (32'(cfg.slots_in_use) > 32'(SLOTS))
            slots_eff = SW'(SLOTS);
        else
            slots_eff = SW'(cfg.slots_in_use);
    end
    assign len = {kw_eff, 3'b000};

    assign key_w[0] = item_reg.key_word0;
    assign key_w[1] = item_reg.key_word1;
    assign key_w[2] = item_reg.key_word2;
    assign key_w[3] = item_reg.key_word3;

    always_comb
    begin
        case (cmd.step[2:1])
            2'd0:    word64 = item_reg.key_word0;
            2'd1:    word64 = item_reg.key_word1;
            2'd2:    word64 = item_reg.key_word2;
            default: word64 = item_reg.key_word3;
        endcase
    end
    assign word32 = cmd.step[0] ? word64[63:32] : word64[31:0];

    // shared multiplier
    always_comb
    begin
        mul_a = h_reg;
        mul_b = PR2;
        case (cmd.op)
            OP_LANE_A:
            begin
                mul_a = word32;
                mul_b = PR2;
            end
            OP_LANE_B:
            begin
                mul_a = rotl32(v_reg[cmd.step[1:0]] + t_reg, 13);
                mul_b = PR1;
            end
            OP_TAIL_A:
            begin
                mul_a = word32;
                mul_b = PR3;
            end
            OP_TAIL_B:
            begin
                mul_a = rotl32(h_reg + t_reg, 17);
                mul_b = PR4;
            end
            OP_FIN_A:
            begin
                mul_a = h_reg ^ (h_reg >> 15);
                mul_b = PR2;
            end
            OP_FIN_B:
            begin
                mul_a = h_reg ^ (h_reg >> 13);
                mul_b = PR3;
            end
            OP_DIVQ:
            begin
                mul_a = h_reg >> 3;
                mul_b = DIV3_RECIP;
            end
            default:
            begin
                mul_a = h_reg;
                mul_b = PR2;
            end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    assign conv_sum = rotl32(v_reg[0], 1) + rotl32(v_reg[1], 7) + rotl32(v_reg[2], 12)
                    + rotl32(v_reg[3], 18) + 32'(len);

    // h / len for len of 8, 16, 24, 32 bytes
    always_comb
    begin
        case (kw_eff)
            3'd2:    divq = h_reg >> 4;
            3'd3:    divq = {1'b0, prod[63:33]};
            3'd4:    divq = h_reg >> 5;
            default: divq = h_reg >> 3;
        endcase
    end

    // one remainder bit per step
    assign rem_sh   = {rem_reg[SW-1:0], h_reg[31]};
    assign rem_next = (rem_sh >= {1'b0, slots_eff}) ? rem_sh - {1'b0, slots_eff} : rem_sh;

    assign bkt_idx  = BW'(tbl_mod(item_reg.table_index)) * BW'(SLOTS) + BW'(rem_reg);
    assign head     = bkt_rdata_reg[BKW-1:CW];
    assign cnt      = bkt_rdata_reg[CW-1:0];
    assign rd_way   = way_add(head, way_reg);
    assign ins_way  = way_add(head, cnt);
    assign head_inc = way_add(head, CW'(1));

    always_comb
    begin
        for (int k = 0; k < KEY_WORDS_MAX; k++)
            key_row[k*64 +: 64] = (3'(k) < kw_eff) ? key_w[k] : 64'd0;
    end

    assign st_key  = ent_rdata_reg[EWID-1:96];
    assign st_off  = ent_rdata_reg[95:32];
    assign st_size = ent_rdata_reg[31:0];

    always_comb
    begin
        key_eq = 1'b1;
        for (int k = 0; k < KEY_WORDS_MAX; k++)
        begin
            if (3'(k) < kw_eff && st_key[k*64 +: 64] != key_w[k])
                key_eq = 1'b0;
        end
    end
    assign hit = key_eq && !(cfg.simple_mode && st_size != item_reg.byte_count)
               && (st_off != item_reg.byte_offset);

    assign recycle = (cnt != '0) && ((used_reg >= cfg.entry_limit) || (cnt >= CW'(WAYS)));
    assign bkt_new = recycle ? {head_inc, cnt} : {head, cnt + CW'(1)};

    assign sts.clear_last = (clr_reg == BW'(NBKT - 1));
    assign sts.kw_eff     = kw_eff;
    assign sts.mode       = item_reg.mode;
    assign sts.hit        = hit;
    assign sts.bkt_empty  = (cnt == '0);
    assign sts.way_last   = (SUMW'(way_reg) + SUMW'(1)) == SUMW'(cnt);
    assign result         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.op == OP_INSERT && !recycle && used_reg != 16'hFFFF)
                used_reg <= used_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                item_reg <= item;
                res_reg  <= '0;
                v_reg[0] <= PR1 + PR2;
                v_reg[1] <= PR2;
                v_reg[2] <= 32'd0;
                v_reg[3] <= 32'd0 - PR1;
                h_reg    <= PR5 + 32'(len);
            end
            OP_LANE_A, OP_TAIL_A: t_reg <= prod[31:0];
            OP_LANE_B:  v_reg[cmd.step[1:0]] <= prod[31:0];
            OP_CONV:    h_reg <= conv_sum;
            OP_TAIL_B, OP_FIN_A, OP_FIN_B: h_reg <= prod[31:0];
            OP_FIN_C:   h_reg <= h_reg ^ (h_reg >> 16);
            OP_DIVQ:
            begin
                h_reg   <= h_reg ^ divq;
                rem_reg <= '0;
            end
            OP_MOD_STEP:
            begin
                rem_reg <= rem_next;
                h_reg   <= h_reg << 1;
            end
            OP_WAY_CLR: way_reg <= '0;
            OP_ENT_CMP:
            begin
                way_reg <= way_reg + CW'(1);
                if (hit)
                begin
                    res_reg.found        <= 1'b1;
                    res_reg.match_offset <= st_off;
                    res_reg.match_size   <= st_size;
                end
            end
            OP_INSERT:
            begin
                res_reg.inserted <= 1'b1;
                res_reg.recycled <= recycle;
            end
            default: ;
        endcase
    end

    // bucket head/count memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLEAR)
            bkt_mem[clr_reg] <= '0;
        else if (cmd.op == OP_INSERT)
            bkt_mem[bkt_idx] <= bkt_new;
        if (cmd.op == OP_BKT_RD)
            bkt_rdata_reg <= bkt_mem[bkt_idx];
    end

    // entry memory: key row, offset, size
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_INSERT)
            ent_mem[{bkt_idx, ins_way}] <= {key_row, item_reg.byte_offset,
                                            item_reg.byte_count};
        if (cmd.op == OP_ENT_RD)
            ent_rdata_reg <= ent_mem[{bkt_idx, rd_way}];
    end

`ifndef NO_ASSERTIONS
    a_no_insert_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INSERT |-> !res_reg.found) else $error("insert after a hit");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> used_reg == $past(used_reg) + 16'd1)
        else $error("entry count jumped");
`endif

endmodule

// ===== design/dedupe_similarity_index.sv =====
// Top level of the deduplication similarity index: config registers,
// controller and datapath. Depends on dsi_pkg, dsi_ctrl, dsi_dp.
//
// An item is taken when start is high and busy low; its result is valid on
// result when done is high for one cycle, and cannot be held off. Each item
// runs the hash rounds on the shared 32x32 multiplier, the 32-step remainder
// loop and a walk of the one-port entry memory over up to WAYS bucket
// entries, then an insert on a miss when item.mode is set. After reset a
// clearing pass zeroes all TABLES*SLOTS buckets; busy stays high
// meanwhile. Config writes are taken at any time but belong in idle periods.
module dedupe_similarity_index
    import dsi_pkg::*;
#(
    parameter int TABLES        = 4,
    parameter int SLOTS         = 1024,
    parameter int WAYS          = 8,
    parameter int KEY_WORDS_MAX = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        done,
    output result_t     result
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_words    <= RST_KEY_WORDS;
            cfg_reg.simple_mode  <= RST_SIMPLE_MODE;
            cfg_reg.slots_in_use <= RST_SLOTS;
            cfg_reg.entry_limit  <= RST_ENTRY_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_KEY_WORDS:   cfg_reg.key_words    <= pwdata[2:0];
                REG_SIMPLE_MODE: cfg_reg.simple_mode  <= pwdata[0];
                REG_SLOTS:       cfg_reg.slots_in_use <= pwdata[10:0];
                REG_ENTRY_LIMIT: cfg_reg.entry_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_KEY_WORDS:   prdata = 32'(cfg_reg.key_words);
            REG_SIMPLE_MODE: prdata = 32'(cfg_reg.simple_mode);
            REG_SLOTS:       prdata = 32'(cfg_reg.slots_in_use);
            REG_ENTRY_LIMIT: prdata = 32'(cfg_reg.entry_limit);
            default:         prdata = '0;
        endcase
    end

    dsi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dsi_dp #(
        .TABLES        (TABLES),
        .SLOTS         (SLOTS),
        .WAYS          (WAYS),
        .KEY_WORDS_MAX (KEY_WORDS_MAX)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule
